### hdl/sorted_node_table_with_distance_assert.svh
// assertion macros for the node table
`ifndef SORTED_NODE_TABLE_WITH_DISTANCE_ASSERT_SVH
`define SORTED_NODE_TABLE_WITH_DISTANCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SNT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SNT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SNT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SNT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/snt_pkg.sv
`timescale 1ns / 1ps
package snt_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned IdW     = 31;
  localparam int unsigned CoordW  = 28;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned DistW   = 37;
  localparam int unsigned SqW     = 58;
  localparam int unsigned RootW   = 37;
  localparam int unsigned TimeMul = 5904;

  localparam logic [1:0] ReqAppend = 2'd0;
  localparam logic [1:0] ReqSort   = 2'd1;
  localparam logic [1:0] ReqLookup = 2'd2;
  localparam logic [1:0] ReqDist   = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StRange    = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IdW-1:0]           node_id;
    logic signed [CoordW-1:0] x_coord;
    logic signed [CoordW-1:0] y_coord;
    logic [IdxW-1:0]          first_index;
    logic [IdxW-1:0]          second_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdxW-1:0]  found_index;
    logic [DistW-1:0] distance_value;
  } out_word_t;

  // datapath operations chosen by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_RD_A, OP_RD_B, OP_LATCH_A, OP_LATCH_B, OP_WR_A, OP_WR_B,
    OP_APPEND, OP_SQ_X, OP_SQ_Y, OP_ROOT_START, OP_TIME_MUL
  } dp_op_e;

endpackage

### hdl/snt_ctrl.sv
`timescale 1ns / 1ps
// sequencer: append, quicksort, binary search and distance
module snt_ctrl #(
  parameter int unsigned TableDepth = snt_pkg::TableDepthDefault,
  parameter int unsigned AddrW = $clog2(TableDepth),
  parameter int unsigned CntW = $clog2(TableDepth + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  snt_pkg::in_word_t      in_word_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output snt_pkg::out_word_t     out_word_o,
  input  logic                   mode_i,
  // datapath command and status
  output snt_pkg::dp_op_e        op_o,
  output logic [AddrW-1:0]       addr_o,
  input  logic [snt_pkg::IdW-1:0] rd_id_i,
  input  logic                   root_busy_i,
  input  logic [snt_pkg::DistW-1:0] dist_i
);
  import snt_pkg::*;
  `include "sorted_node_table_with_distance_assert.svh"

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001, S_LOOKUP = 16'h0002, S_LK_CMP = 16'h0004,
    S_DIST   = 16'h0008, S_DROOT  = 16'h0010, S_DONE   = 16'h0020,
    S_SPOP   = 16'h0040, S_MED    = 16'h0080, S_MED_CMP = 16'h0100,
    S_SWAP   = 16'h0200, S_SCAN   = 16'h0400, S_SCAN_CMP = 16'h0800,
    S_PUSH   = 16'h1000, S_SETUP  = 16'h2000, S_SW_CMP = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  localparam int unsigned StkD = 64;
  localparam int unsigned SpW = 7;
  localparam logic signed [CntW:0] One = 1;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  in_word_t req_q, req_d;
  out_word_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  // general index registers (signed to express -1)
  logic signed [CntW:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic signed [CntW:0] p_q, p_d, sa_q, sa_d, sb_q, sb_d;
  logic [2:0] step_q, step_d;
  logic [IdW-1:0] t0_q, t0_d, t1_q, t1_d, piv_q, piv_d;
  logic [3:0] ret_q, ret_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [AddrW-1:0] stk_lo [StkD];
  logic [AddrW-1:0] stk_hi [StkD];
  logic stk_we;
  logic [AddrW-1:0] stk_wlo, stk_whi;
  logic [AddrW-1:0] pop_lo, pop_hi;

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_lo[sp_q[5:0]] <= stk_wlo;
      stk_hi[sp_q[5:0]] <= stk_whi;
    end
    pop_lo <= stk_lo[sp_d[5:0]];
    pop_hi <= stk_hi[sp_d[5:0]];
  end

  assign in_stall   = (state_q != S_IDLE) || out_valid_q;
  assign out_valid  = out_valid_q;
  assign out_word_o = res_q;

  function automatic logic [AddrW-1:0] ad(input logic signed [CntW:0] v);
    ad = v[AddrW-1:0];
  endfunction

  // swap-return codes
  localparam logic [3:0] RetPiv = 4'd0, RetScan = 4'd1, RetFinal = 4'd2;

  // main sequencer
  always_comb begin
    logic signed [CntW:0] mid;
    state_d = state_q; count_d = count_q; req_d = req_q; res_d = res_q;
    out_valid_d = out_valid_q; lo_d = lo_q; hi_d = hi_q; i_d = i_q; j_d = j_q;
    p_d = p_q; sa_d = sa_q; sb_d = sb_q; step_d = step_q; t0_d = t0_q;
    t1_d = t1_q; piv_d = piv_q; ret_d = ret_q; sp_d = sp_q;
    op_o = OP_NONE; addr_o = '0;
    stk_we = 1'b0; stk_wlo = '0; stk_whi = '0;
    mid = lo_q + ((hi_q - lo_q) >>> 1);
    if (out_valid_q && !out_stall) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          req_d = in_word_i;
          res_d = '0;
          case (in_word_i.req_type)
            ReqAppend: begin
              if (count_q >= CntW'(TableDepth)) begin
                res_d.status = StFull;
              end else begin
                op_o = OP_APPEND; addr_o = count_q[AddrW-1:0];
                count_d = count_q + 1'b1;
              end
              state_d = S_OUT;
            end
            ReqSort: begin
              if (count_q < CntW'(2)) begin
                state_d = S_OUT;
              end else begin
                lo_d = '0; hi_d = $signed({1'b0, count_q}) - One; sp_d = '0;
                state_d = S_MED; step_d = '0;
              end
            end
            ReqLookup: begin
              lo_d = '0; hi_d = $signed({1'b0, count_q}) - One;
              state_d = S_LOOKUP;
            end
            default: begin
              if (32'(in_word_i.first_index) >= 32'(count_q) ||
                  32'(in_word_i.second_index) >= 32'(count_q)) begin
                res_d.status = StRange; state_d = S_OUT;
              end else begin
                state_d = S_DIST; step_d = '0;
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall) begin
          out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_LOOKUP: begin
        if (lo_q > hi_q) begin
          res_d.status = StNotFound; res_d.found_index = '0; state_d = S_OUT;
        end else begin
          op_o = OP_RD_A; addr_o = ad(mid); p_d = mid; state_d = S_LK_CMP;
          step_d = '0;
        end
      end
      S_LK_CMP: begin
        if (step_q == 3'd0) begin
          step_d = 3'd1;
        end else if (rd_id_i == req_q.node_id) begin
          res_d.found_index = IdxW'(p_q); state_d = S_OUT;
        end else begin
          if (req_q.node_id < rd_id_i) hi_d = p_q - One;
          else lo_d = p_q + One;
          state_d = S_LOOKUP;
        end
      end
      S_DIST: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: begin op_o = OP_RD_A; addr_o = AddrW'(req_q.first_index); end
          3'd1: op_o = OP_LATCH_A;
          3'd2: begin op_o = OP_RD_B; addr_o = AddrW'(req_q.second_index); end
          3'd3: op_o = OP_LATCH_B;
          3'd4: op_o = OP_SQ_X;
          3'd5: op_o = OP_SQ_Y;
          default: begin op_o = OP_ROOT_START; state_d = S_DROOT; step_d = '0; end
        endcase
      end
      S_DROOT: begin
        if (!root_busy_i) begin
          if (step_q == 3'd0 && mode_i) begin
            op_o = OP_TIME_MUL; step_d = 3'd1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        res_d.distance_value = dist_i; state_d = S_OUT;
      end
      // pop a range from the stack
      S_SPOP: begin
        if (step_q == 3'd0) begin
          if (sp_q == '0) begin
            state_d = S_OUT;
          end else begin
            sp_d = sp_q - 1'b1; step_d = 3'd1;
          end
        end else begin
          lo_d = $signed((CntW+1)'(pop_lo)); hi_d = $signed((CntW+1)'(pop_hi));
          state_d = S_MED; step_d = '0;
        end
      end
      // median of three: read lo, mid, hi
      S_MED: begin
        if (lo_q >= hi_q) begin
          state_d = S_SPOP; step_d = '0;
        end else begin
          step_d = step_q + 1'b1;
          case (step_q)
            3'd0: begin op_o = OP_RD_A; addr_o = ad(lo_q); end
            3'd1: begin op_o = OP_RD_A; addr_o = ad(mid); t0_d = rd_id_i; end
            3'd2: begin op_o = OP_RD_A; addr_o = ad(hi_q); t1_d = rd_id_i; end
            default: begin
              state_d = S_MED_CMP;
              piv_d = rd_id_i;
            end
          endcase
        end
      end
      S_MED_CMP: begin
        logic signed [CntW:0] big, sml;
        logic [IdW-1:0] bid, sid;
        if (t0_q > t1_q) begin
          big = lo_q; sml = mid; bid = t0_q; sid = t1_q;
        end else begin
          big = mid; sml = lo_q; bid = t1_q; sid = t0_q;
        end
        if (piv_q > bid) sa_d = big;
        else if (piv_q < sid) sa_d = sml;
        else sa_d = hi_q;
        sb_d = lo_q; ret_d = RetPiv; state_d = S_SWAP; step_d = '0;
      end
      // swap entries sa and sb through datapath registers
      S_SWAP: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: begin op_o = OP_RD_A; addr_o = ad(sa_q); end
          3'd1: op_o = OP_LATCH_A;
          3'd2: begin op_o = OP_RD_B; addr_o = ad(sb_q); end
          3'd3: op_o = OP_LATCH_B;
          3'd4: begin op_o = OP_WR_B; addr_o = ad(sa_q); end
          default: begin
            op_o = OP_WR_A; addr_o = ad(sb_q); step_d = '0;
            case (ret_q)
              RetPiv: begin
                i_d = lo_q + One; j_d = lo_q + One; state_d = S_SETUP;
              end
              RetScan: begin
                i_d = i_q + One; j_d = j_q + One; state_d = S_SCAN;
              end
              default: state_d = S_PUSH;
            endcase
          end
        endcase
      end
      // fetch the pivot id from lo
      S_SETUP: begin
        step_d = step_q + 1'b1;
        if (step_q == 3'd0) begin
          op_o = OP_RD_A; addr_o = ad(lo_q);
        end else if (step_q == 3'd2) begin
          piv_d = rd_id_i; state_d = S_SCAN; step_d = '0;
        end
      end
      S_SCAN: begin
        if (j_q > hi_q) begin
          sa_d = lo_q; sb_d = i_q - One; p_d = i_q - One; ret_d = RetFinal;
          state_d = S_SWAP; step_d = '0;
        end else begin
          op_o = OP_RD_A; addr_o = ad(j_q); state_d = S_SCAN_CMP; step_d = '0;
        end
      end
      S_SCAN_CMP: begin
        if (step_q == 3'd0) begin
          step_d = 3'd1;
        end else if (rd_id_i < piv_q) begin
          sa_d = j_q; sb_d = i_q; ret_d = RetScan; state_d = S_SWAP; step_d = '0;
        end else begin
          j_d = j_q + One; state_d = S_SCAN;
        end
      end
      S_PUSH: begin
        if (p_q - lo_q > hi_q - p_q) begin
          if (sp_q < SpW'(StkD)) begin
            stk_we = 1'b1; stk_wlo = ad(lo_q); stk_whi = ad(p_q - One);
            sp_d = sp_q + 1'b1;
          end
          lo_d = p_q + One;
        end else begin
          if (sp_q < SpW'(StkD)) begin
            stk_we = 1'b1; stk_wlo = ad(p_q + One); stk_whi = ad(hi_q);
            sp_d = sp_q + 1'b1;
          end
          hi_d = p_q - One;
        end
        state_d = S_MED; step_d = '0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; out_valid_q <= 1'b0; sp_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; out_valid_q <= out_valid_d;
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; res_q <= res_d; lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d;
    j_q <= j_d; p_q <= p_d; sa_q <= sa_d; sb_q <= sb_d; step_q <= step_d;
    t0_q <= t0_d; t1_q <= t1_d; piv_q <= piv_d; ret_q <= ret_d;
  end

  `SNT_ASSERT_IMPL(a_count_max, clk_i, rst_ni, (count_q <= CntW'(TableDepth)), "count above depth")
  `SNT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall, out_valid_q, "result dropped")
  `SNT_ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, (state_q != S_IDLE) |-> in_stall, "accept while busy")
  `SNT_ASSERT_IMPL(a_stk_bound, clk_i, rst_ni, (sp_q <= SpW'(StkD)), "stack overrun")
endmodule

### hdl/snt_dpath.sv
`timescale 1ns / 1ps
// node memories, difference, squares, shift-subtract root and time scale
module snt_dpath #(
  parameter int unsigned TableDepth = snt_pkg::TableDepthDefault,
  parameter int unsigned AddrW = $clog2(TableDepth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  snt_pkg::dp_op_e             op_i,
  input  logic [AddrW-1:0]            addr_i,
  input  snt_pkg::in_word_t           req_i,
  input  logic                        mode_i,
  output logic [snt_pkg::IdW-1:0]     rd_id_o,
  output logic                        root_busy_o,
  output logic [snt_pkg::DistW-1:0]   dist_o
);
  import snt_pkg::*;

  logic [IdW-1:0]    id_mem [TableDepth];
  logic [CoordW-1:0] x_mem  [TableDepth];
  logic [CoordW-1:0] y_mem  [TableDepth];
  logic [IdW-1:0]    rid_q;
  logic [CoordW-1:0] rx_q, ry_q;
  logic [IdW-1:0]    aid_q, bid_q;
  logic [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [CoordW:0]   dx_q, dy_q;
  logic [SqW-1:0]    sq_q;
  logic              we;
  logic [IdW-1:0]    wid;
  logic [CoordW-1:0] wx, wy;
  logic [RootW-1:0]  root_q;
  logic [RootW+1:0]  rem_q;
  logic [SqW+15:0]   rad_q;
  logic [5:0]        k_q;
  logic              busy_q;
  logic [DistW-1:0]  dist_q;

  // write port selection
  always_comb begin
    we = 1'b0; wid = req_i.node_id; wx = req_i.x_coord; wy = req_i.y_coord;
    case (op_i)
      OP_APPEND: we = 1'b1;
      OP_WR_A: begin we = 1'b1; wid = aid_q; wx = ax_q; wy = ay_q; end
      OP_WR_B: begin we = 1'b1; wid = bid_q; wx = bx_q; wy = by_q; end
      default: we = 1'b0;
    endcase
  end

  // read data is held until the next read
  always_ff @(posedge clk_i) begin
    if (we) begin
      id_mem[addr_i] <= wid; x_mem[addr_i] <= wx; y_mem[addr_i] <= wy;
    end
    if (op_i == OP_RD_A || op_i == OP_RD_B) begin
      rid_q <= id_mem[addr_i]; rx_q <= x_mem[addr_i]; ry_q <= y_mem[addr_i];
    end
  end

  // operand latches and arithmetic
  always_ff @(posedge clk_i) begin
    logic signed [CoordW:0] ddx, ddy;
    ddx = $signed({ax_q[CoordW-1], ax_q}) - $signed({bx_q[CoordW-1], bx_q});
    ddy = $signed({ay_q[CoordW-1], ay_q}) - $signed({by_q[CoordW-1], by_q});
    case (op_i)
      OP_LATCH_A: begin aid_q <= rid_q; ax_q <= rx_q; ay_q <= ry_q; end
      OP_LATCH_B: begin bid_q <= rid_q; bx_q <= rx_q; by_q <= ry_q; end
      OP_SQ_X: begin
        dx_q <= ddx[CoordW] ? -ddx : ddx;
        dy_q <= ddy[CoordW] ? -ddy : ddy;
      end
      default: ;
    endcase
    if (op_i == OP_SQ_Y) begin
      sq_q <= SqW'(dx_q * dx_q) + SqW'(dy_q * dy_q);
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; k_q <= '0;
    end else if (op_i == OP_ROOT_START) begin
      busy_q <= 1'b1; k_q <= 6'd36;
    end else if (busy_q) begin
      if (k_q == 6'd0) busy_q <= 1'b0;
      else k_q <= k_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [RootW+1:0] r, t;
    if (op_i == OP_ROOT_START) begin
      rad_q <= {sq_q, 16'h0}; root_q <= '0; rem_q <= '0;
    end else if (busy_q) begin
      r = {rem_q[RootW-1:0], rad_q[SqW+15 -: 2]};
      t = {root_q, 2'b01};
      rad_q <= {rad_q[SqW+13:0], 2'b00};
      if (r >= t) begin
        rem_q <= r - t; root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q <= r; root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (op_i == OP_TIME_MUL) dist_q <= DistW'((RootW+13)'(root_q) * 13'(TimeMul) >> 16);
    else if (op_i == OP_ROOT_START) dist_q <= '0;
  end

  assign rd_id_o = rid_q;
  assign root_busy_o = busy_q || (op_i == OP_ROOT_START);
  assign dist_o = mode_i ? dist_q : root_q;
endmodule

### hdl/sorted_node_table_with_distance.sv
`timescale 1ns / 1ps
// append: writes on accept; lookup: binary search, a read and compare per probe
// distance: squares, the 37-step one-bit-a-cycle root, time scale in time mode
// sort: median-of-three quicksort with a range stack, about n log n compares
// one request at a time; a result register parts the two sides
// reset clears node count, mode and control; node memories keep garbage
module sorted_node_table_with_distance #(
  parameter int unsigned TableDepth = snt_pkg::TableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid,
  output logic               in_stall,
  input  snt_pkg::in_word_t  in_word_i,
  output logic               out_valid,
  input  logic               out_stall,
  output snt_pkg::out_word_t out_word_o
);
  import snt_pkg::*;
  localparam int unsigned AddrW = $clog2(TableDepth);

  logic mode_q;
  dp_op_e op;
  logic [AddrW-1:0] addr;
  logic [IdW-1:0] rd_id;
  logic busy;
  logic [DistW-1:0] dist_val;
  in_word_t req;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  assign req = in_word_i;

  snt_ctrl #(.TableDepth(TableDepth)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_word_i, .out_valid, .out_stall,
    .out_word_o, .mode_i(mode_q), .op_o(op), .addr_o(addr),
    .rd_id_i(rd_id), .root_busy_i(busy), .dist_i(dist_val)
  );

  snt_dpath #(.TableDepth(TableDepth)) u_dpath (
    .clk_i, .rst_ni, .op_i(op), .addr_i(addr), .req_i(req), .mode_i(mode_q),
    .rd_id_o(rd_id), .root_busy_o(busy), .dist_o(dist_val)
  );
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import snt_pkg::*;

  localparam int unsigned Depth     = TableDepthDefault;
  localparam logic        ModeDist  = 1'b0;
  localparam logic        ModeTime  = 1'b1;
  localparam int unsigned CycleCap  = 8000000;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned IdleWait  = 80;
  localparam logic [IdW-1:0]    IdMax = {IdW{1'b1}};
  localparam logic [CoordW-1:0] CMax  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CMin  = {1'b1, {(CoordW-1){1'b0}}};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word_i = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word_o;

  sorted_node_table_with_distance uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid(in_valid), .in_stall(in_stall), .in_word_i(in_word_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_word_o(out_word_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the node table
  logic [IdW-1:0]           tbl_id [Depth];
  logic signed [CoordW-1:0] tbl_x  [Depth];
  logic signed [CoordW-1:0] tbl_y  [Depth];
  int unsigned              tbl_count = 0;
  logic                     tbl_mode = ModeDist;

  in_word_t  word_q [$];
  out_word_t result_q [$];
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        calm = 1'b0;
  logic        took = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // stimulus-side view, used to pick ids and indices
  logic [IdW-1:0] known_ids [$];
  int unsigned    gen_count = 0;

  task automatic swap_nodes(int a, int b);
    logic [IdW-1:0] ti;
    logic signed [CoordW-1:0] tc;
    ti = tbl_id[a]; tbl_id[a] = tbl_id[b]; tbl_id[b] = ti;
    tc = tbl_x[a];  tbl_x[a]  = tbl_x[b];  tbl_x[b]  = tc;
    tc = tbl_y[a];  tbl_y[a]  = tbl_y[b];  tbl_y[b]  = tc;
  endtask

  // quicksort by id, median of three, pivot parked at the left end
  task automatic sort_nodes();
    int slo [64];
    int shi [64];
    int sp, lo, hi, mid, big, sml, piv, i, p;
    if (tbl_count < 2) return;
    slo[0] = 0;
    shi[0] = tbl_count - 1;
    sp = 1;
    while (sp > 0) begin
      sp--;
      lo = slo[sp];
      hi = shi[sp];
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tbl_id[lo] > tbl_id[mid]) begin
          big = lo; sml = mid;
        end else begin
          big = mid; sml = lo;
        end
        if (tbl_id[hi] > tbl_id[big]) piv = big;
        else if (tbl_id[hi] < tbl_id[sml]) piv = sml;
        else piv = hi;
        swap_nodes(piv, lo);
        i = lo + 1;
        for (int j = lo + 1; j <= hi; j++) begin
          if (tbl_id[j] < tbl_id[lo]) begin
            swap_nodes(j, i);
            i++;
          end
        end
        swap_nodes(lo, i - 1);
        p = i - 1;
        if (p - lo > hi - p) begin
          if (sp < 64) begin
            slo[sp] = lo; shi[sp] = p - 1; sp++;
          end
          lo = p + 1;
        end else begin
          if (sp < 64) begin
            slo[sp] = p + 1; shi[sp] = hi; sp++;
          end
          hi = p - 1;
        end
      end
    end
  endtask

  // floor(sqrt(sq * 2^16))
  function automatic logic [DistW-1:0] scaled_root(logic [63:0] sq);
    logic [79:0] v;
    logic [39:0] r;
    logic [39:0] t;
    v = {16'd0, sq} << 16;
    r = '0;
    for (int k = 39; k >= 0; k--) begin
      t = r | (40'd1 << k);
      if ({40'd0, t} * {40'd0, t} <= v) r = t;
    end
    return r[DistW-1:0];
  endfunction

  task automatic predict(input in_word_t w, output out_word_t res);
    int first, last, md;
    logic signed [63:0] dx, dy;
    logic [63:0] d;
    res = '0;
    res.status = StOk;
    case (w.req_type)
      ReqAppend: begin
        if (tbl_count >= Depth) res.status = StFull;
        else begin
          tbl_id[tbl_count] = w.node_id;
          tbl_x[tbl_count]  = w.x_coord;
          tbl_y[tbl_count]  = w.y_coord;
          tbl_count++;
        end
      end
      ReqSort: sort_nodes();
      ReqLookup: begin
        first = 0;
        last = int'(tbl_count) - 1;
        res.status = StNotFound;
        while (first <= last) begin
          md = first + (last - first) / 2;
          if (tbl_id[md] == w.node_id) begin
            res.status = StOk;
            res.found_index = md[IdxW-1:0];
            break;
          end
          if (w.node_id < tbl_id[md]) last = md - 1;
          else first = md + 1;
        end
      end
      default: begin
        if (w.first_index >= tbl_count || w.second_index >= tbl_count) res.status = StRange;
        else begin
          dx = 64'(tbl_x[w.first_index]) - 64'(tbl_x[w.second_index]);
          dy = 64'(tbl_y[w.first_index]) - 64'(tbl_y[w.second_index]);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          d = 64'(scaled_root(dx * dx + dy * dy));
          if (tbl_mode == ModeTime) d = (d * TimeMul) >> 16;
          res.distance_value = d[DistW-1:0];
        end
      end
    endcase
  endtask

  // random word of a given request, every field filled
  function automatic in_word_t rand_word(logic [1:0] req);
    in_word_t w;
    w.req_type     = req;
    w.node_id      = IdW'($urandom);
    w.x_coord      = CoordW'($urandom);
    w.y_coord      = CoordW'($urandom);
    w.first_index  = IdxW'($urandom);
    w.second_index = IdxW'($urandom);
    return w;
  endfunction

  task automatic push_append(logic [IdW-1:0] id, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    in_word_t w;
    w = rand_word(ReqAppend);
    w.node_id = id; w.x_coord = x; w.y_coord = y;
    word_q.push_back(w);
    if (gen_count < Depth) begin
      known_ids.push_back(id);
      gen_count++;
    end
  endtask

  task automatic push_lookup(logic [IdW-1:0] id);
    in_word_t w;
    w = rand_word(ReqLookup);
    w.node_id = id;
    word_q.push_back(w);
  endtask

  task automatic push_dist(int a, int b);
    in_word_t w;
    w = rand_word(ReqDist);
    w.first_index = IdxW'(a); w.second_index = IdxW'(b);
    word_q.push_back(w);
  endtask

  // mostly well-formed requests against what is stored
  task automatic push_random();
    int r;
    logic [IdW-1:0] id;
    r = $urandom_range(999);
    if (r < 380) begin
      case ($urandom_range(3))
        0: id = IdW'($urandom_range(40));
        1: id = IdMax - IdW'($urandom_range(3));
        default: id = IdW'($urandom);
      endcase
      push_append(id, CoordW'($urandom), CoordW'($urandom));
    end else if (r < 388) begin
      word_q.push_back(rand_word(ReqSort));
    end else if (r < 690) begin
      if (known_ids.size() > 0 && $urandom_range(3) != 0)
        push_lookup(known_ids[$urandom_range(known_ids.size() - 1)]);
      else
        word_q.push_back(rand_word(ReqLookup));
    end else begin
      if (gen_count > 0 && $urandom_range(7) != 0)
        push_dist($urandom_range(gen_count - 1), $urandom_range(gen_count - 1));
      else
        word_q.push_back(rand_word(ReqDist));
    end
  endtask

  task automatic drain();
    wait (word_q.size() == 0 && !in_valid && result_q.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender: offer the next word, hold it while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || took)) begin
      if (word_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        in_word_i <= word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && words_sent >= 200) begin
      hold_done <= 1'b1;
      hold_left <= HoldLen;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  // predict accepted words, check returned words
  always @(posedge clk_i) begin
    out_word_t exp_w;
    out_word_t got_w;
    cycles <= cycles + 1;
    took <= in_valid && !in_stall;
    if (cfg_we_i) tbl_mode = cfg_wdata_i;
    if (in_valid && !in_stall) begin
      predict(in_word_i, exp_w);
      result_q.push_back(exp_w);
      words_sent <= words_sent + 1;
    end
    if (out_valid && !out_stall) begin
      got_w = out_word_o;
      if (result_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %h", got_w);
      end else begin
        exp_w = result_q.pop_front();
        if (got_w.status !== exp_w.status || got_w.found_index !== exp_w.found_index ||
            got_w.distance_value !== exp_w.distance_value) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp st %0d idx %0d dist %0d, got st %0d idx %0d dist %0d",
                     exp_w.status, exp_w.found_index, exp_w.distance_value,
                     got_w.status, got_w.found_index, got_w.distance_value);
        end
      end
    end
    if (cycles >= CycleCap) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_mode(ModeDist);

    // directed: empty table, extremes, duplicates, unsorted lookup
    word_q.push_back(rand_word(ReqSort));
    push_lookup(IdW'(5));
    push_dist(0, 0);
    push_append('0, CMin, CMin);
    push_append(IdMax, CMax, CMax);
    push_append(IdW'(7), '0, '0);
    push_append(IdW'(7), '1, CoordW'(1));
    push_append(IdW'(3), CoordW'(5), -CoordW'(9));
    push_dist(0, 1);
    push_dist(1, 0);
    push_dist(2, 2);
    push_dist(0, 5);
    push_dist(5, 0);
    push_lookup(IdW'(7));
    push_lookup(IdW'(3));
    push_lookup(IdMax);
    word_q.push_back(rand_word(ReqSort));
    push_lookup('0);
    push_lookup(IdMax);
    push_lookup(IdW'(7));
    push_lookup(IdW'(4));
    push_dist(0, 4);
    drain();

    // random, distance mode, with a stretch of no idling
    for (int n = 0; n < 200; n++) push_random();
    wait (words_sent >= 100);
    calm = 1'b1;
    wait (words_sent >= 200);
    calm = 1'b0;
    drain();

    // random, time mode
    write_mode(ModeTime);
    for (int n = 0; n < 190; n++) push_random();
    drain();

    // fill the table, overflow it, sort the whole lot
    while (gen_count < Depth)
      push_append(IdW'($urandom), CoordW'($urandom), CoordW'($urandom));
    for (int n = 0; n < 3; n++) push_append(IdW'($urandom), CMax, CMin);
    word_q.push_back(rand_word(ReqSort));
    push_dist(0, Depth - 1);
    push_dist(Depth - 1, 0);
    for (int n = 0; n < 30; n++) push_random();
    drain();

    write_mode(ModeDist);
    for (int n = 0; n < 30; n++) push_random();
    push_dist(Depth - 1, Depth - 2);
    drain();

    if (mismatches == 0 && result_q.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/snt_pkg.sv
hdl/snt_ctrl.sv
hdl/snt_dpath.sv
hdl/sorted_node_table_with_distance.sv
dv/tb_top.sv
